// ===== rtl/huffman_tree_decoder_unit_assert.svh =====
// assertion macros for the huffman tree decoder unit
// no dependencies; included by the top level
`ifndef HUFFMAN_TREE_DECODER_UNIT_ASSERT_SVH
`define HUFFMAN_TREE_DECODER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define HTD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define HTD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define HTD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define HTD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/htd_pkg.sv =====
// shared constants and types for the huffman tree decoder unit
// no dependencies
package htd_pkg;

    localparam int NODE_COUNT  = 512;
    localparam int SYMBOL_BITS = 8;
    localparam int TOP_BIT     = 7;
    localparam int ADDR_W      = $clog2(NODE_COUNT);
    localparam int IDX_W       = 9;
    localparam int OUT_SYM_W   = 8;
    localparam int IN_DATA_W   = 48;

    typedef logic [IDX_W-1:0]  node_idx_t;
    typedef logic [ADDR_W-1:0] node_addr_t;

    typedef struct packed {
        node_idx_t              left;
        node_idx_t              right;
        logic                   leaf;
        logic [SYMBOL_BITS-1:0] sym;
    } node_entry_t;

    typedef struct packed {
        logic                 err;
        logic [OUT_SYM_W-1:0] sym;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_BIT   = 4'b0010,
        ST_LEAF  = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_DECODE = 1'b1;

endpackage

// ===== rtl/huffman_tree_decoder_unit.sv =====
// huffman tree decoder unit: node table plus a bit-serial tree walker
// depends on htd_pkg and huffman_tree_decoder_unit_assert.svh
//
// input channel s_*: s_tuser selects the item kind (0 write node, 1 decode byte).
// a write transfer stores one node table entry and gives no result.
// a decode transfer carries one compressed byte, its count of valid low bits and
// s_tlast, which sends the walk back to the root after the byte.
// result channel m_*: one transfer per decoded symbol or error; m_tuser is the
// error flag, m_tlast marks the last result caused by the byte.
// a byte is walked bit by bit: a bit that hits an absent branch is handled in the bit
// state alone, any other bit takes a node table read, then the leaf check on the
// registered read data; a closing step then passes on the pending result. a byte
// makes up to 8 dependent reads of the single table read port. s_tready is high only
// while no byte is being walked, so the next byte waits until this one is done.
// each result is held one step in a pending register so that m_tlast can be set
// once the byte is done; a step that yields a result stalls while that register and
// the output register are both full and m_tready is low. nothing is lost or repeated.
// reset empties both result registers and sets the walk index, not its entry, to root;
// the node table is not cleared and must be written before it is used.
`include "huffman_tree_decoder_unit_assert.svh"

module huffman_tree_decoder_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // node_index, left_child, right_child, is_leaf, leaf_symbol, data_byte, valid_bits
    input  logic [htd_pkg::IN_DATA_W-1:0] s_tdata,
    // action
    input  logic [0:0]                    s_tuser,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // symbol
    output logic [htd_pkg::OUT_SYM_W-1:0] m_tdata,
    // error
    output logic [0:0]                    m_tuser,
    output logic                          m_tlast
);
    import htd_pkg::*;

    node_entry_t mem [NODE_COUNT];

    state_t      state_reg, state_next;
    node_idx_t   cur_node_reg, cur_node_next;
    node_entry_t cur_entry_reg, cur_entry_next;
    node_entry_t root_reg, root_next;
    node_idx_t   child_reg, child_next;
    logic [7:0]  data_reg, data_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        fin_reg, fin_next;
    logic        pend_valid_reg, pend_valid_next;
    result_t     pend_reg, pend_next;
    logic        m_valid_reg, m_valid_next;
    result_t     m_res_reg, m_res_next;
    logic        m_last_reg, m_last_next;
    node_entry_t rd_data_reg;

    node_idx_t   in_idx;
    node_entry_t in_entry;
    logic [7:0]  in_data;
    logic [3:0]  in_vb;
    logic [3:0]  vb_sat;
    logic        wr_en;
    logic        rd_en;
    logic        out_free;
    logic        cur_bit;
    node_idx_t   child;
    logic        absent;
    logic        can_push;
    logic [2:0]  bit_pos;

    assign in_idx         = s_tdata[8:0];
    assign in_entry.left  = s_tdata[17:9];
    assign in_entry.right = s_tdata[26:18];
    assign in_entry.leaf  = s_tdata[27];
    assign in_entry.sym   = SYMBOL_BITS'(s_tdata[35:28]);
    assign in_data        = s_tdata[43:36];
    assign in_vb          = s_tdata[47:44];
    assign vb_sat         = (in_vb > 4'(TOP_BIT + 1)) ? 4'(TOP_BIT + 1) : in_vb;

    assign s_tready = (state_reg == ST_IDLE);
    assign wr_en    = s_tvalid && s_tready && (s_tuser[0] == ACT_WRITE)
                      && (32'(in_idx) < NODE_COUNT);

    assign out_free = !m_valid_reg || m_tready;
    assign can_push = !pend_valid_reg || out_free;
    assign bit_pos  = 3'(cnt_reg - 4'd1);
    assign cur_bit  = data_reg[bit_pos];
    assign child    = cur_bit ? cur_entry_reg.right : cur_entry_reg.left;
    assign absent   = (child == '0) || (32'(child) >= NODE_COUNT);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[ADDR_W'(in_idx)] <= in_entry;
        end
        if (rd_en) begin
            rd_data_reg <= mem[ADDR_W'(child)];
        end
    end

    always_comb begin
        state_next      = state_reg;
        cur_node_next   = cur_node_reg;
        cur_entry_next  = cur_entry_reg;
        root_next       = root_reg;
        child_next      = child_reg;
        data_next       = data_reg;
        cnt_next        = cnt_reg;
        fin_next        = fin_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        m_valid_next    = m_valid_reg;
        m_res_next      = m_res_reg;
        m_last_next     = m_last_reg;
        rd_en           = 1'b0;

        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (wr_en) begin
                    if (in_idx == '0) begin
                        root_next = in_entry;
                    end
                    if (in_idx == cur_node_reg) begin
                        cur_entry_next = in_entry;
                    end
                end
                if (s_tvalid && s_tuser[0] == ACT_DECODE) begin
                    data_next  = in_data;
                    cnt_next   = vb_sat;
                    fin_next   = s_tlast;
                    state_next = (vb_sat == 4'd0) ? ST_FLUSH : ST_BIT;
                end
            end
            ST_BIT: begin
                if (absent) begin
                    if (can_push) begin
                        if (pend_valid_reg) begin
                            m_valid_next = 1'b1;
                            m_res_next   = pend_reg;
                            m_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_next.err   = 1'b1;
                        pend_next.sym   = '0;
                        cur_node_next   = '0;
                        cur_entry_next  = root_reg;
                        cnt_next        = cnt_reg - 4'd1;
                        state_next      = (cnt_reg == 4'd1) ? ST_FLUSH : ST_BIT;
                    end
                end else begin
                    rd_en      = 1'b1;
                    child_next = child;
                    state_next = ST_LEAF;
                end
            end
            ST_LEAF: begin
                if (rd_data_reg.leaf) begin
                    if (can_push) begin
                        if (pend_valid_reg) begin
                            m_valid_next = 1'b1;
                            m_res_next   = pend_reg;
                            m_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_next.err   = 1'b0;
                        pend_next.sym   = OUT_SYM_W'(rd_data_reg.sym);
                        cur_node_next   = '0;
                        cur_entry_next  = root_reg;
                        cnt_next        = cnt_reg - 4'd1;
                        state_next      = (cnt_reg == 4'd1) ? ST_FLUSH : ST_BIT;
                    end
                end else begin
                    cur_node_next  = child_reg;
                    cur_entry_next = rd_data_reg;
                    cnt_next       = cnt_reg - 4'd1;
                    state_next     = (cnt_reg == 4'd1) ? ST_FLUSH : ST_BIT;
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg || out_free) begin
                    if (pend_valid_reg) begin
                        m_valid_next    = 1'b1;
                        m_res_next      = pend_reg;
                        m_last_next     = 1'b1;
                        pend_valid_next = 1'b0;
                    end
                    if (fin_reg) begin
                        cur_node_next  = '0;
                        cur_entry_next = root_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cur_node_reg   <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cur_node_reg   <= cur_node_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        cur_entry_reg <= cur_entry_next;
        root_reg      <= root_next;
        child_reg     <= child_next;
        data_reg      <= data_next;
        cnt_reg       <= cnt_next;
        fin_reg       <= fin_next;
        pend_reg      <= pend_next;
        m_res_reg     <= m_res_next;
        m_last_reg    <= m_last_next;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_res_reg.sym;
    assign m_tuser[0] = m_res_reg.err;
    assign m_tlast    = m_last_reg;

    `HTD_ASSERT_IMP(a_idle_no_pending, aclk, aresetn, state_reg == ST_IDLE, !pend_valid_reg)
    `HTD_ASSERT_IMP(a_walk_has_bits, aclk, aresetn,
        state_reg == ST_BIT || state_reg == ST_LEAF, cnt_reg != 4'd0)
    `HTD_ASSERT_IMP(a_error_zero_symbol, aclk, aresetn,
        m_valid_reg && m_res_reg.err, m_res_reg.sym == '0)
    `HTD_ASSERT_NXT(a_leaf_after_read, aclk, aresetn,
        state_reg == ST_BIT && !absent, state_reg == ST_LEAF)

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for huffman_tree_decoder_unit: loads code trees, streams
// compressed bytes and checks every decoded symbol and error against its own tree walk
// depends on htd_pkg and the huffman_tree_decoder_unit rtl
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import htd_pkg::*;

    // s_tdata field offsets
    localparam int LEFT_LSB  = 9;
    localparam int RIGHT_LSB = 18;
    localparam int LEAF_POS  = 27;
    localparam int SYM_LSB   = 28;
    localparam int DATA_LSB  = 36;
    localparam int VBITS_LSB = 44;

    typedef struct packed {
        logic [OUT_SYM_W-1:0] sym;
        logic                 err;
        logic                 last;
    } decoded_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [IN_DATA_W-1:0] s_tdata;
    logic [0:0]           s_tuser;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [OUT_SYM_W-1:0] m_tdata;
    logic [0:0]           m_tuser;
    logic                 m_tlast;

    // local copy of the node table and the walk position
    node_entry_t tree_copy [NODE_COUNT];
    bit          slot_written [NODE_COUNT];
    node_idx_t   walk_node;
    decoded_t    pending_symbols [$];

    // current code tree, for building well-formed messages
    node_idx_t   tree_leaves [$];
    logic [31:0] code_of [NODE_COUNT];
    int          code_len [NODE_COUNT];

    int s_idle_pct;
    int m_idle_pct;
    int items_sent;
    int results_seen;
    int error_results;
    int mismatch_count;
    int trees_loaded;
    int messages_sent;

    huffman_tree_decoder_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= m_idle_pct);
    end

    function automatic void flag_mismatch(input string detail);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch %0d at %0t: %s", mismatch_count, $time, detail);
        end
    endfunction

    // updates the table copy for an accepted write, or walks the tree for an accepted byte and queues what it yields
    task automatic decode_predict(input logic act, input logic [IN_DATA_W-1:0] d,
                                  input logic fin);
        node_entry_t entry;
        node_idx_t   slot;
        node_idx_t   child;
        logic [7:0]  bits;
        int          nbits;
        int          produced;
        decoded_t    res;
        produced = 0;
        if (act == ACT_WRITE) begin
            slot        = d[IDX_W-1:0];
            entry.left  = d[LEFT_LSB +: IDX_W];
            entry.right = d[RIGHT_LSB +: IDX_W];
            entry.leaf  = d[LEAF_POS];
            entry.sym   = d[SYM_LSB +: SYMBOL_BITS];
            tree_copy[slot]    = entry;
            slot_written[slot] = 1'b1;
        end else begin
            bits  = d[DATA_LSB +: 8];
            nbits = (d[VBITS_LSB +: 4] > TOP_BIT + 1) ? TOP_BIT + 1 : d[VBITS_LSB +: 4];
            for (int i = nbits - 1; i >= 0; i--) begin
                child = bits[i] ? tree_copy[walk_node].right : tree_copy[walk_node].left;
                if (child == '0) begin
                    res.sym = '0;
                    res.err = 1'b1;
                    res.last = 1'b0;
                    pending_symbols.push_back(res);
                    produced++;
                    walk_node = '0;
                end else if (tree_copy[child].leaf) begin
                    res.sym = tree_copy[child].sym;
                    res.err = 1'b0;
                    res.last = 1'b0;
                    pending_symbols.push_back(res);
                    produced++;
                    walk_node = '0;
                end else begin
                    walk_node = child;
                end
            end
            if (produced > 0) begin
                pending_symbols[pending_symbols.size() - 1].last = 1'b1;
            end
            if (fin) begin
                walk_node = '0;
            end
        end
    endtask

    // true when decoding these bits only touches table entries already written
    function automatic bit walk_reads_written(input logic [7:0] bits, input int nbits);
        node_idx_t cur;
        node_idx_t child;
        cur = walk_node;
        for (int i = nbits - 1; i >= 0; i--) begin
            if (!slot_written[cur]) return 1'b0;
            child = bits[i] ? tree_copy[cur].right : tree_copy[cur].left;
            if (child == '0) begin
                cur = '0;
            end else if (!slot_written[child]) begin
                return 1'b0;
            end else if (tree_copy[child].leaf) begin
                cur = '0;
            end else begin
                cur = child;
            end
        end
        return 1'b1;
    endfunction

    task automatic send_transfer(input logic act, input logic [IN_DATA_W-1:0] d,
                                 input logic fin);
        while ($urandom_range(0, 99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= act;
        s_tlast  <= fin;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        decode_predict(act, d, fin);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_node(input node_idx_t slot, input node_idx_t left,
                             input node_idx_t right, input logic leaf,
                             input logic [7:0] sym);
        logic [IN_DATA_W-1:0] d;
        d = {4'($urandom), 8'($urandom), sym, leaf, right, left, slot};
        send_transfer(ACT_WRITE, d, 1'($urandom));
    endtask

    task automatic send_byte(input logic [7:0] data, input logic [3:0] vbits,
                             input logic fin);
        logic [IN_DATA_W-1:0] d;
        int                   nbits;
        nbits = (vbits > TOP_BIT + 1) ? TOP_BIT + 1 : vbits;
        // never let a byte run into a table entry that was not loaded
        if (!walk_reads_written(data, nbits)) begin
            vbits = 4'd0;
        end
        d = {vbits, data, 4'($urandom), 32'($urandom)};
        send_transfer(ACT_DECODE, d, fin);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_symbols.size() != 0) @(negedge aclk);
    endtask

    // random prefix tree by repeated splitting of leaves, loaded in random order
    task automatic load_random_tree(input int splits);
        node_idx_t   members [$];
        node_idx_t   open_leaves [$];
        bit          taken [NODE_COUNT];
        node_entry_t shape [NODE_COUNT];
        node_idx_t   kids [2];
        node_idx_t   f;
        node_idx_t   slot;
        int          pick;
        int          absent;
        taken[0] = 1'b1;
        members.push_back('0);
        open_leaves.push_back('0);
        code_of[0]  = '0;
        code_len[0] = 0;
        for (int k = 0; k < splits; k++) begin
            pick = $urandom_range(0, open_leaves.size() - 1);
            f = open_leaves[pick];
            open_leaves.delete(pick);
            absent = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1) : 2;
            for (int b = 0; b < 2; b++) begin
                if (b == absent) begin
                    kids[b] = '0;
                end else begin
                    do slot = node_idx_t'($urandom_range(1, NODE_COUNT - 1));
                    while (taken[slot]);
                    taken[slot]    = 1'b1;
                    code_of[slot]  = (code_of[f] << 1) | b;
                    code_len[slot] = code_len[f] + 1;
                    members.push_back(slot);
                    open_leaves.push_back(slot);
                    kids[b] = slot;
                end
            end
            shape[f].left  = kids[0];
            shape[f].right = kids[1];
            shape[f].leaf  = 1'b0;
            shape[f].sym   = 8'($urandom);
        end
        foreach (open_leaves[k]) begin
            shape[open_leaves[k]].left  = node_idx_t'($urandom);
            shape[open_leaves[k]].right = node_idx_t'($urandom);
            shape[open_leaves[k]].leaf  = 1'b1;
            shape[open_leaves[k]].sym   = 8'($urandom);
        end
        for (int k = members.size() - 1; k > 0; k--) begin
            pick = $urandom_range(0, k);
            slot = members[k];
            members[k] = members[pick];
            members[pick] = slot;
        end
        foreach (members[k]) begin
            send_node(members[k], shape[members[k]].left, shape[members[k]].right,
                      shape[members[k]].leaf, shape[members[k]].sym);
        end
        tree_leaves = open_leaves;
        trees_loaded++;
    endtask

    // encodes random leaves of the current tree into bytes, optionally corrupted
    task automatic send_message(input int n_syms, input bit broken);
        bit         stream [$];
        node_idx_t  leaf;
        logic [7:0] byte_v;
        logic [3:0] vbits;
        int         take;
        int         pos;
        bit         is_end;
        for (int n = 0; n < n_syms; n++) begin
            leaf = tree_leaves[$urandom_range(0, tree_leaves.size() - 1)];
            for (int j = code_len[leaf] - 1; j >= 0; j--) begin
                stream.push_back(code_of[leaf][j]);
            end
        end
        if (broken && stream.size() > 1) begin
            pos = $urandom_range(0, stream.size() - 1);
            case ($urandom_range(0, 2))
                0: stream[pos] = !stream[pos];
                1: stream.delete(pos);
                default: begin
                    while (stream.size() > pos + 1) stream.pop_back();
                end
            endcase
        end
        while (stream.size() > 0) begin
            take   = (stream.size() > 8) ? 8 : stream.size();
            is_end = (stream.size() <= 8);
            byte_v = 8'($urandom);
            for (int j = 0; j < take; j++) begin
                byte_v[take - 1 - j] = stream.pop_front();
            end
            vbits = 4'(take);
            if (take == 8 && $urandom_range(0, 7) == 0) begin
                vbits = 4'($urandom_range(9, 15));
            end
            send_byte(byte_v, vbits, is_end);
        end
        messages_sent++;
    endtask

    // small fixed tree: 0 -> left leaf 511 (0xff), right 5; 5 -> left absent, right leaf 6
    task automatic test_extremes_and_errors();
        send_node(9'd511, 9'd511, 9'd511, 1'b1, 8'hFF);
        send_node(9'd6, 9'd0, 9'd0, 1'b1, 8'h00);
        send_node(9'd5, 9'd0, 9'd6, 1'b0, 8'h00);
        send_node(9'd0, 9'd511, 9'd5, 1'b0, 8'h00);
        send_byte(8'h00, 4'd8, 1'b0);
        send_byte(8'hFF, 4'd8, 1'b0);
        send_byte(8'h02, 4'd2, 1'b0);
        send_byte(8'h5A, 4'd0, 1'b0);
        send_byte(8'h00, 4'd15, 1'b0);
        send_byte(8'hAA, 4'd9, 1'b0);
        wait_drained();
    endtask

    task automatic test_walk_state();
        // end-of-message flag drops a half-finished walk
        send_byte(8'h01, 4'd1, 1'b1);
        send_byte(8'h00, 4'd1, 1'b0);
        // code split across two bytes
        send_byte(8'h01, 4'd1, 1'b0);
        send_byte(8'h01, 4'd1, 1'b0);
        // node rewritten while the walk stands on it
        send_byte(8'h01, 4'd1, 1'b0);
        send_node(9'd5, 9'd0, 9'd511, 1'b0, 8'h00);
        send_byte(8'h01, 4'd1, 1'b0);
        send_byte(8'h01, 4'd1, 1'b0);
        send_byte(8'h00, 4'd1, 1'b0);
        // absent branch at the root, then a root marked as leaf
        send_node(9'd0, 9'd0, 9'd5, 1'b0, 8'h00);
        send_byte(8'h00, 4'd1, 1'b0);
        send_byte(8'h80, 4'd8, 1'b1);
        send_node(9'd0, 9'd511, 9'd5, 1'b1, 8'hAB);
        send_byte(8'h00, 4'd3, 1'b1);
    endtask

    task automatic test_random_traffic(input int s_pct, input int m_pct, input int quota);
        int start;
        s_idle_pct = s_pct;
        m_idle_pct = m_pct;
        start = items_sent;
        while (items_sent - start < quota) begin
            load_random_tree($urandom_range(1, 9));
            repeat ($urandom_range(2, 5)) begin
                case ($urandom_range(0, 9))
                    7: begin
                        repeat ($urandom_range(1, 3)) begin
                            send_byte(8'($urandom), 4'($urandom), 1'($urandom));
                        end
                    end
                    8: send_node(node_idx_t'($urandom), node_idx_t'($urandom),
                                 node_idx_t'($urandom), 1'($urandom), 8'($urandom));
                    9: send_message($urandom_range(1, 6), 1'b1);
                    default: send_message($urandom_range(1, 8), 1'b0);
                endcase
            end
        end
    endtask

    always @(posedge aclk) begin
        decoded_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (m_tuser[0]) error_results++;
            if (pending_symbols.size() == 0) begin
                flag_mismatch($sformatf("unexpected transfer symbol %0h error %0b last %0b",
                                        m_tdata, m_tuser[0], m_tlast));
            end else begin
                want = pending_symbols.pop_front();
                if (m_tdata !== want.sym) begin
                    flag_mismatch($sformatf("symbol expected %0h got %0h", want.sym, m_tdata));
                end
                if (m_tuser[0] !== want.err) begin
                    flag_mismatch($sformatf("error expected %0b got %0b", want.err, m_tuser[0]));
                end
                if (m_tlast !== want.last) begin
                    flag_mismatch($sformatf("last expected %0b got %0b", want.last, m_tlast));
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        s_tlast    = 1'b0;
        m_tready   = 1'b0;
        walk_node  = '0;
        s_idle_pct = 29;
        m_idle_pct = 67;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_extremes_and_errors();
        test_walk_state();
        test_random_traffic(29, 67, 40);
        test_random_traffic(67, 29, 40);
        test_random_traffic(0, 0, 40);

        wait_drained();
        repeat (40) @(negedge aclk);
        $display("%0d input transfers over %0d code trees and %0d messages", items_sent,
                 trees_loaded, messages_sent);
        $display("%0d results checked, %0d of them decode errors, %0d mismatches",
                 results_seen, error_results, mismatch_count);
        if (mismatch_count == 0 && pending_symbols.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
